// File: rtl/core/lzwd_pkg.sv
// Package for the LZW stream decoder: request/response beat types, codes, constants.
// No dependencies.
package lzwd_pkg;

    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 2'd3;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_KEPT     = 3'd2;
    localparam logic [2:0] ST_SKIPPED  = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;
    localparam logic [2:0] ST_FINISHED = 3'd5;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    localparam int CLEAR_CODE = 256;
    localparam int FIRST_FREE = 257;
    localparam int INIT_WIDTH = 9;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       last;
    } rsp_t;

endpackage

// File: rtl/core/lzw_compress_decoder.sv
// LZW (.Z body) decoder top level: bit packing, dictionary memories, chain walk, output stack.
// Depends on lzwd_pkg.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | req_t  (req_type, in_byte)
//  rsp     | out | rsp_valid/ready    | rsp_t  (status, out_byte, last)
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// Pulls read the stack memory. Pushes that finish no code, and a clear, go straight to rsp;
// the first code passes S_FIN; others walk S_RD/S_WALK per chain link, plus an S_RD for KwKwK,
// on the single prefix/suffix read port. One request at a time; rsp stalls hold the block.
// No clearing pass: dictionary entries below 256 are synthesized, others are written before use.
module lzw_compress_decoder
    import lzwd_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = 1 << MAX_CODE_BITS;
    localparam int AW    = MAX_CODE_BITS;
    localparam int NW    = MAX_CODE_BITS + 1;
    localparam logic [4:0] MCB = 5'(MAX_CODE_BITS);

    typedef enum logic [2:0] {S_IDLE, S_POP, S_RD, S_WALK, S_FIN, S_RSP} state_t;

    logic [AW-1:0] prefix_mem [DEPTH];
    logic [7:0]    suffix_mem [DEPTH];
    logic [7:0]    stack_mem  [DEPTH];

    state_t           state_reg;
    rsp_t             rsp_reg;
    logic [4:0]       max_bits_reg;
    logic             block_mode_reg;
    logic [COUNT_WIDTH-1:0] skip_left_reg, out_left_reg;
    logic [NW-1:0]    stack_count_reg;
    logic [23:0]      bit_buffer_reg;
    logic [4:0]       bit_count_reg, group_bytes_reg, code_width_reg;
    logic [NW-1:0]    next_entry_reg;
    logic [AW-1:0]    prev_code_reg, code_reg, k_reg;
    logic [7:0]       last_char_reg;
    logic             first_pending_reg, discard_pending_reg;

    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    pre_q;
    logic [7:0]       suf_q, stk_q;
    logic             k_low_reg;

    // combinational helpers
    logic [4:0]  eff_max;
    logic [NW:0] maxc;
    logic [23:0] buf_n;
    logic [5:0]  cnt_n;
    logic [4:0]  grp_n;
    logic [15:0] code_n;

    always_comb
    begin
        eff_max = max_bits_reg;
        if (eff_max < 5'(INIT_WIDTH)) eff_max = 5'(INIT_WIDTH);
        if (eff_max > MCB) eff_max = MCB;
        if (code_width_reg != 5'(INIT_WIDTH) && code_width_reg == eff_max)
            maxc = (NW+1)'(1) << eff_max;
        else
            maxc = ((NW+1)'(1) << code_width_reg) - (NW+1)'(1);
        buf_n = bit_buffer_reg | (24'(req.in_byte) << bit_count_reg);
        cnt_n = 6'(bit_count_reg) + 6'd8;
        grp_n = group_bytes_reg + 5'd1;
        if (grp_n >= code_width_reg) grp_n = '0;
        code_n = 16'(buf_n & ((24'd1 << code_width_reg) - 24'd1));
    end

    // dictionary and stack memories
    logic          dict_we;
    logic [AW-1:0] dict_wa, dict_wp;
    logic [7:0]    dict_ws;
    logic          stk_we;
    logic [AW-1:0] stk_wa, stk_ra;
    logic [7:0]    stk_wd;

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            prefix_mem[dict_wa] <= dict_wp;
            suffix_mem[dict_wa] <= dict_ws;
        end
        pre_q <= prefix_mem[rd_addr];
        suf_q <= suffix_mem[rd_addr];
        if (stk_we)
            stack_mem[stk_wa] <= stk_wd;
        stk_q <= stack_mem[stk_ra];
    end

    // chain walk: k_reg is the node being read this cycle
    logic [7:0] suf_eff;
    logic       full_stop;
    assign suf_eff   = k_low_reg ? k_reg[7:0] : suf_q;
    assign full_stop = stack_count_reg >= NW'(DEPTH - 1);

    logic [4:0] drop_rem;
    assign drop_rem = (group_bytes_reg != '0) ? code_width_reg - group_bytes_reg : '0;

    logic clear_hit;
    assign clear_hit = block_mode_reg && code_n == 16'(CLEAR_CODE) &&
                       next_entry_reg != NW'(CLEAR_CODE);

    // KwKwK: code not yet in the dictionary, seen on the first read of the walk
    logic kwk_hit;
    assign kwk_hit = NW'(code_reg) >= next_entry_reg && k_reg == code_reg &&
                     stack_count_reg == '0;

    logic [COUNT_WIDTH-1:0] skip_dec, out_dec;
    logic [NW-1:0]          stack_dec;
    logic                   limit_hit;
    assign skip_dec  = skip_left_reg - COUNT_WIDTH'(1);
    assign out_dec   = out_left_reg - COUNT_WIDTH'(1);
    assign stack_dec = stack_count_reg - NW'(1);
    assign limit_hit = out_left_reg == COUNT_WIDTH'(1);

    assign req_ready = (state_reg == S_IDLE) && !cfg_we;
    assign rsp_valid = (state_reg == S_RSP);
    assign rsp       = rsp_reg;
    assign stk_ra    = AW'(stack_dec);

    logic grow;
    logic [NW-1:0] ne_after;

    always_comb
    begin
        rd_addr  = k_reg;
        dict_we  = 1'b0;
        dict_wa  = next_entry_reg[AW-1:0];
        dict_wp  = prev_code_reg;
        dict_ws  = suf_eff;
        stk_we   = 1'b0;
        stk_wa   = stack_count_reg[AW-1:0];
        stk_wd   = suf_eff;
        ne_after = next_entry_reg;
        if (state_reg == S_IDLE && req_valid && req_ready && req.req_type == REQ_PUSH &&
            out_left_reg != '0 && stack_count_reg == '0 && !discard_pending_reg &&
            cnt_n >= 6'(code_width_reg) && first_pending_reg)
        begin
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = code_n[7:0];
        end
        if (state_reg == S_RD && kwk_hit)
        begin
            stk_we = 1'b1;
            stk_wd = last_char_reg;
        end
        if (state_reg == S_WALK)
        begin
            stk_we = 1'b1;
            if (next_entry_reg < (NW'(1) << eff_max) &&
                (k_low_reg || full_stop))
            begin
                dict_we  = 1'b1;
                ne_after = next_entry_reg + NW'(1);
            end
        end
    end

    // growth check uses next_entry after any update
    assign grow = (17'(ne_after) > 17'(maxc)) && code_width_reg < 5'd16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            rsp_reg             <= '0;
            max_bits_reg        <= 5'd16;
            block_mode_reg      <= 1'b1;
            skip_left_reg       <= '0;
            out_left_reg        <= '0;
            stack_count_reg     <= '0;
            bit_buffer_reg      <= '0;
            bit_count_reg       <= '0;
            group_bytes_reg     <= '0;
            code_width_reg      <= 5'(INIT_WIDTH);
            next_entry_reg      <= NW'(FIRST_FREE);
            prev_code_reg       <= '0;
            code_reg            <= '0;
            k_reg               <= '0;
            k_low_reg           <= 1'b0;
            last_char_reg       <= '0;
            first_pending_reg   <= 1'b1;
            discard_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_BITS:   max_bits_reg <= cfg_data[4:0];
                    REG_BLOCK_MODE:
                    begin
                        block_mode_reg <= cfg_data[0];
                        if (first_pending_reg)
                            next_entry_reg <= cfg_data[0] ? NW'(FIRST_FREE) : NW'(CLEAR_CODE);
                    end
                    REG_SKIP_COUNT: skip_left_reg <= COUNT_WIDTH'(cfg_data);
                    REG_OUT_LIMIT:  out_left_reg  <= COUNT_WIDTH'(cfg_data);
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        if (out_left_reg == '0)
                        begin
                            rsp_reg   <= '{status: ST_FINISHED, out_byte: 8'd0, last: 1'b0};
                            state_reg <= S_RSP;
                        end
                        else if (req.req_type == REQ_PULL)
                        begin
                            if (stack_count_reg == '0)
                            begin
                                rsp_reg   <= '{status: ST_NONE, out_byte: 8'd0, last: 1'b0};
                                state_reg <= S_RSP;
                            end
                            else
                                state_reg <= S_POP;
                        end
                        else if (stack_count_reg != '0)
                        begin
                            rsp_reg   <= '{status: ST_BUSY, out_byte: 8'd0, last: 1'b0};
                            state_reg <= S_RSP;
                        end
                        else if (discard_pending_reg)
                        begin
                            rsp_reg         <= '0;
                            state_reg       <= S_RSP;
                            group_bytes_reg <= group_bytes_reg - 5'd1;
                            if (group_bytes_reg == 5'd1)
                                discard_pending_reg <= 1'b0;
                        end
                        else if (cnt_n < 6'(code_width_reg))
                        begin
                            rsp_reg         <= '0;
                            state_reg       <= S_RSP;
                            group_bytes_reg <= grp_n;
                            bit_buffer_reg  <= buf_n;
                            bit_count_reg   <= 5'(cnt_n);
                        end
                        else
                        begin
                            rsp_reg  <= '0;
                            code_reg <= AW'(code_n);
                            if (first_pending_reg)
                            begin
                                bit_buffer_reg    <= buf_n >> code_width_reg;
                                bit_count_reg     <= 5'(cnt_n - 6'(code_width_reg));
                                group_bytes_reg   <= grp_n;
                                first_pending_reg <= 1'b0;
                                last_char_reg     <= code_n[7:0];
                                prev_code_reg     <= AW'(code_n);
                                stack_count_reg   <= NW'(1);
                                state_reg         <= S_FIN;
                            end
                            else if (clear_hit)
                            begin
                                next_entry_reg      <= NW'(CLEAR_CODE);
                                code_width_reg      <= 5'(INIT_WIDTH);
                                bit_buffer_reg      <= '0;
                                bit_count_reg       <= '0;
                                group_bytes_reg     <= (grp_n != '0) ? code_width_reg - grp_n : '0;
                                discard_pending_reg <= (grp_n != '0);
                                state_reg           <= S_RSP;
                            end
                            else
                            begin
                                bit_buffer_reg  <= buf_n >> code_width_reg;
                                bit_count_reg   <= 5'(cnt_n - 6'(code_width_reg));
                                group_bytes_reg <= grp_n;
                                k_reg           <= AW'(code_n);
                                state_reg       <= S_RD;
                            end
                        end
                    end
                end
                S_RD:
                begin
                    // KwKwK: push last_char then continue from prev_code
                    if (kwk_hit)
                    begin
                        stack_count_reg <= NW'(1);
                        k_reg           <= prev_code_reg;
                        k_low_reg       <= (prev_code_reg < AW'(256));
                    end
                    else
                    begin
                        k_low_reg <= (k_reg < AW'(256));
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    stack_count_reg <= stack_count_reg + NW'(1);
                    if (k_low_reg || full_stop)
                    begin
                        last_char_reg  <= suf_eff;
                        prev_code_reg  <= code_reg;
                        next_entry_reg <= ne_after;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        k_reg     <= pre_q;
                        state_reg <= S_RD;
                    end
                end
                S_FIN:
                begin
                    if (grow)
                    begin
                        code_width_reg      <= code_width_reg + 5'd1;
                        bit_buffer_reg      <= '0;
                        bit_count_reg       <= '0;
                        group_bytes_reg     <= drop_rem;
                        discard_pending_reg <= (drop_rem != '0);
                    end
                    state_reg <= S_RSP;
                end
                S_POP:
                begin
                    if (skip_left_reg != '0)
                    begin
                        skip_left_reg   <= skip_dec;
                        stack_count_reg <= stack_dec;
                        rsp_reg         <= '{status: ST_SKIPPED, out_byte: stk_q, last: 1'b0};
                    end
                    else
                    begin
                        out_left_reg    <= out_dec;
                        stack_count_reg <= limit_hit ? '0 : stack_dec;
                        rsp_reg         <= '{status: ST_KEPT, out_byte: stk_q, last: limit_hit};
                    end
                    state_reg <= S_RSP;
                end
                S_RSP:
                begin
                    if (rsp_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: verif/tb_lzw_compress_decoder.sv
// Self-checking testbench for lzw_compress_decoder: a shadow decoder predicts every rsp beat.
// Push bytes are built from the shadow state so codes stay at or below the next free entry.
// Depends on lzwd_pkg and the RTL top level.
module tb_lzw_compress_decoder;
    import lzwd_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lzw_compress_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow decoder state
    bit [15:0]   sh_prefix [65536];
    bit [7:0]    sh_suffix [65536];
    bit [7:0]    sh_stack  [65536];
    int unsigned sh_depth, sh_bits, sh_nbits, sh_group, sh_width, sh_next, sh_prev, sh_char;
    bit          sh_first, sh_discard;
    bit [31:0]   sh_skip, sh_left;
    int unsigned cf_max_bits;
    bit          cf_block;

    rsp_t        rsp_expected [$];
    int          errors;
    int unsigned cycles;
    bit          quiet;
    bit          hold_req;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("lzw_compress_decoder regression: fail");
            $finish;
        end
    end

    function automatic int unsigned eff_max();
        int unsigned m;
        m = cf_max_bits;
        if (m < INIT_WIDTH) m = INIT_WIDTH;
        if (m > MAX_CODE_BITS_DEF) m = MAX_CODE_BITS_DEF;
        return m;
    endfunction

    function automatic int unsigned top_code(int unsigned w);
        int unsigned e;
        e = eff_max();
        if (w != INIT_WIDTH && w == e) return 1 << e;
        return (1 << w) - 1;
    endfunction

    task automatic drop_group();
        int unsigned rem;
        rem = (sh_group != 0) ? sh_width - sh_group : 0;
        sh_bits = 0;
        sh_nbits = 0;
        sh_group = rem;
        sh_discard = (rem != 0);
    endtask

    task automatic expand_code(int unsigned code);
        int unsigned k, n;
        k = code;
        n = 0;
        if (k >= sh_next)
        begin
            sh_stack[n] = sh_char[7:0];
            n++;
            k = sh_prev;
        end
        while (k >= 256 && n < 65535)
        begin
            sh_stack[n] = sh_suffix[k & 16'hFFFF];
            n++;
            k = sh_prefix[k & 16'hFFFF];
        end
        sh_char = sh_suffix[k & 16'hFFFF];
        sh_stack[n] = sh_char[7:0];
        n++;
        sh_depth = n;
        if (sh_next < (1 << eff_max()))
        begin
            sh_prefix[sh_next & 16'hFFFF] = sh_prev[15:0];
            sh_suffix[sh_next & 16'hFFFF] = sh_char[7:0];
            sh_next++;
        end
        sh_prev = code;
    endtask

    task automatic take_code(int unsigned code);
        if (sh_first)
        begin
            sh_first = 1'b0;
            sh_char = code & 8'hFF;
            sh_prev = code;
            sh_stack[0] = sh_char[7:0];
            sh_depth = 1;
        end
        else if (cf_block && code == CLEAR_CODE && sh_next != CLEAR_CODE)
        begin
            sh_next = CLEAR_CODE;
            drop_group();
            sh_width = INIT_WIDTH;
            return;
        end
        else
        begin
            expand_code(code);
        end
        if (sh_next > top_code(sh_width) && sh_width < 16)
        begin
            drop_group();
            sh_width++;
        end
    endtask

    task automatic predict_beat(req_t r, output rsp_t e);
        int unsigned code;
        e = '0;
        e.status = ST_ACCEPTED;
        if (sh_left == 0)
        begin
            e.status = ST_FINISHED;
            return;
        end
        if (r.req_type == REQ_PUSH)
        begin
            if (sh_depth != 0)
            begin
                e.status = ST_BUSY;
                return;
            end
            if (sh_discard)
            begin
                sh_group--;
                if (sh_group == 0) sh_discard = 1'b0;
                return;
            end
            sh_bits = (sh_bits | (int'(r.in_byte) << sh_nbits)) & 24'hFFFFFF;
            sh_nbits += 8;
            sh_group++;
            if (sh_group >= sh_width) sh_group = 0;
            if (sh_nbits >= sh_width)
            begin
                code = sh_bits & ((1 << sh_width) - 1);
                sh_bits >>= sh_width;
                sh_nbits -= sh_width;
                take_code(code);
            end
            return;
        end
        if (sh_depth == 0)
        begin
            e.status = ST_NONE;
            return;
        end
        sh_depth--;
        e.out_byte = sh_stack[sh_depth & 16'hFFFF];
        if (sh_skip != 0)
        begin
            sh_skip--;
            e.status = ST_SKIPPED;
            return;
        end
        sh_left--;
        e.status = ST_KEPT;
        if (sh_left == 0)
        begin
            e.last = 1'b1;
            sh_depth = 0;
        end
    endtask

    // byte that completes a code only with one at or below the next free entry
    function automatic logic [7:0] stream_byte();
        int unsigned need, lim, hm, hi, code, mask;
        logic [7:0] b;
        b = 8'($urandom);
        if (sh_depth != 0 || sh_discard || sh_left == 0) return b;
        need = sh_width - sh_nbits;
        if (need > 8) return b;
        mask = (1 << sh_nbits) - 1;
        if (sh_first) lim = 255;
        else if (sh_next >= (1 << eff_max())) lim = sh_next - 1;
        else lim = sh_next;
        if (lim > (1 << sh_width) - 1) lim = (1 << sh_width) - 1;
        if (!sh_first && cf_block && sh_next != CLEAR_CODE && sh_bits == (CLEAR_CODE & mask)
            && $urandom_range(0, 4) == 0)
            code = CLEAR_CODE;
        else
        begin
            hm = (sh_bits > lim) ? 0 : (lim - sh_bits) >> sh_nbits;
            hi = ($urandom_range(0, 7) == 0) ? hm : $urandom_range(0, hm);
            code = (hi << sh_nbits) | sh_bits;
        end
        b = 8'((code >> sh_nbits) & ((1 << need) - 1));
        if (need < 8 && $urandom_range(0, 2) != 0)
            b = b | 8'($urandom << need);
        return b;
    endfunction

    function automatic req_t next_beat();
        req_t r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        r.in_byte = stream_byte();
        if (sh_left == 0) r.req_type = 1'($urandom);
        else if (sh_depth != 0) r.req_type = (pick < 85) ? REQ_PULL : REQ_PUSH;
        else r.req_type = (pick < 90) ? REQ_PUSH : REQ_PULL;
        return r;
    endfunction

    task automatic send_beat(req_t r);
        rsp_t e;
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        predict_beat(r, e);
        rsp_expected.push_back(e);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (rsp_expected.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        req_valid <= 1'b0;
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_BITS: cf_max_bits = val & 5'h1F;
            REG_BLOCK_MODE:
            begin
                cf_block = val[0];
                if (sh_first) sh_next = cf_block ? FIRST_FREE : CLEAR_CODE;
            end
            REG_SKIP_COUNT: sh_skip = val;
            default: sh_left = val;
        endcase
    endtask

    task automatic run_beats(int n);
        repeat (n) send_beat(next_beat());
    endtask

    task automatic test_finished();
        req_t r;
        write_reg(REG_BLOCK_MODE, 32'h0);
        write_reg(REG_BLOCK_MODE, 32'hFFFF_FFFF);
        r = '{req_type: REQ_PUSH, in_byte: 8'hFF};
        send_beat(r);
        r = '{req_type: REQ_PULL, in_byte: 8'h00};
        send_beat(r);
    endtask

    task automatic test_skip_and_limit();
        write_reg(REG_MAX_BITS, 32'd16);
        write_reg(REG_SKIP_COUNT, 32'd3);
        write_reg(REG_OUT_LIMIT, 32'd6);
        run_beats(20);
    endtask

    task automatic test_phase(int unsigned mb, bit bm, logic [31:0] skip, int n);
        write_reg(REG_MAX_BITS, mb);
        write_reg(REG_BLOCK_MODE, 32'(bm));
        write_reg(REG_SKIP_COUNT, skip);
        write_reg(REG_OUT_LIMIT, 32'hFFFF_FFFF);
        run_beats(n);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        run_beats(60);
    endtask

    always @(posedge clk)
    begin
        rsp_t e;
        if (rsp_valid && rsp_ready)
        begin
            if (rsp_expected.size() == 0)
            begin
                $error("unexpected rsp beat status=%0d", rsp.status);
                errors++;
            end
            else
            begin
                e = rsp_expected.pop_front();
                if (rsp.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.out_byte !== e.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", e.out_byte, rsp.out_byte);
                    errors++;
                end
                if (rsp.last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, rsp.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_ready <= 1'b0;
                repeat (299) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        for (i = 0; i < 256; i++) sh_suffix[i] = i[7:0];
        sh_depth = 0;
        sh_bits = 0;
        sh_nbits = 0;
        sh_group = 0;
        sh_width = INIT_WIDTH;
        sh_next = FIRST_FREE;
        sh_prev = 0;
        sh_char = 0;
        sh_first = 1'b1;
        sh_discard = 1'b0;
        sh_skip = 0;
        sh_left = 0;
        cf_max_bits = 16;
        cf_block = 1'b1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_finished();
        test_skip_and_limit();
        test_phase(9, 1'b1, 32'd0, 300);
        test_phase(16, 1'b0, 32'd5, 300);
        test_phase(0, 1'b1, 32'd0, 250);
        test_phase(31, 1'b1, 32'hFFFF_FFFF, 150);
        test_phase(12, 1'b1, 32'd0, 250);
        test_backpressure();
        quiet = 1'b1;
        test_phase(16, 1'b1, 32'd2, 500);

        req_valid <= 1'b0;
        while (rsp_expected.size() != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("lzw_compress_decoder regression: pass");
        else
            $display("lzw_compress_decoder regression: fail");
        $finish;
    end

endmodule
